// ===== design/dxt1_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types, constants and helper functions for the DXT1 block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dxt1_pkg;

  // pixels in one 4x4 block and width of a pixel position
  localparam int unsigned PixelsPerBlock = 16;
  localparam int unsigned PosW           = $clog2(PixelsPerBlock);
  localparam logic [PosW-1:0] LastPos    = PosW'(PixelsPerBlock - 1);

  // alpha codes
  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaClear  = 8'd0;

  // reciprocal of 3 in fixed point, exact floor for sums up to 765
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;

  // reciprocal of 31 in fixed point, exact floor for numerators up to 7920
  localparam int unsigned Recip31      = 8457;
  localparam int unsigned Recip31Shift = 18;

  // reciprocal of 63 in fixed point, exact floor for numerators up to 16096
  localparam int unsigned Recip63      = 16645;
  localparam int unsigned Recip63Shift = 20;

  // one compressed block transaction
  typedef struct packed {
    logic [15:0] endpoint_a;
    logic [15:0] endpoint_b;
    logic [31:0] index_bits;
  } block_t;

  // one decoded pixel transaction
  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [PosW-1:0] pixel_position;
    logic            last_pixel;
  } pixel_t;

  // one palette entry
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  // 5-bit to 8-bit expansion, round(v*255/31) as (v*255+15)/31
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] prod;
    x    = 13'(v) * 13'd255 + 13'd15;
    prod = 27'(x) * 27'(Recip31);
    return 8'(prod >> Recip31Shift);
  endfunction

  // 6-bit to 8-bit expansion, round(v*255/63) as (v*255+31)/63
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] prod;
    x    = 14'(v) * 14'd255 + 14'd31;
    prod = 29'(x) * 29'(Recip63);
    return 8'(prod >> Recip63Shift);
  endfunction

  // truncating divide by 3 of a sum below 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'(Recip3);
    return 8'(prod >> Recip3Shift);
  endfunction

endpackage

`default_nettype wire

// ===== design/dxt1_block_decoder.sv =====
// ----------------------------------------------------------------------------
// dxt1_block_decoder
// Decodes one DXT1 block into sixteen RGBA pixels in row-major order.
// ----------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  block    in         block_t   block_valid / block_stall
//  pixel    out        pixel_t   pixel_valid / pixel_stall
//
//  A block is held in an input register and one pixel per cycle is decoded
//  into the output register, unless pixel_stall holds the output.
//  The next block is taken in the cycle the sixteenth pixel enters the
//  output register, so blocks follow with no gap.
//  A block is first taken into the input register; its first pixel then enters the output register.
//  Reset (rst, synchronous) empties both registers; pixel_stall only freezes.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_block_decoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              block_valid,
  output logic                   block_stall,
  input  wire dxt1_pkg::block_t  block_data,
  output logic                   pixel_valid,
  input  wire logic              pixel_stall,
  output dxt1_pkg::pixel_t       pixel_data
);
  import dxt1_pkg::*;

  block_t           blk;
  logic             blk_full;
  logic [PosW-1:0]  cnt;
  color_t [3:0]     palette;
  logic [1:0]       sel;
  pixel_t           pix_next;
  logic             advance;
  logic             at_last;
  logic             block_accept;

  // palette from the held block
  dxt1_palette u_palette (
    .endpoint_a (blk.endpoint_a),
    .endpoint_b (blk.endpoint_b),
    .palette    (palette)
  );

  // handshake control
  assign advance      = blk_full && (!pixel_valid || !pixel_stall);
  assign at_last      = cnt == LastPos;
  assign block_stall  = blk_full && !(advance && at_last);
  assign block_accept = block_valid && !block_stall;

  // pixel selection
  always_comb begin
    sel                     = blk.index_bits[{cnt, 1'b0} +: 2];
    pix_next.red            = palette[sel].red;
    pix_next.green          = palette[sel].green;
    pix_next.blue           = palette[sel].blue;
    pix_next.alpha          = palette[sel].alpha;
    pix_next.pixel_position = cnt;
    pix_next.last_pixel     = at_last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_full    <= 1'b0;
      cnt         <= '0;
      pixel_valid <= 1'b0;
    end else begin
      if (block_accept) begin
        blk_full <= 1'b1;
      end else if (advance && at_last) begin
        blk_full <= 1'b0;
      end
      if (advance) begin
        cnt         <= cnt + 1'b1;
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (block_accept) begin
      blk <= block_data;
    end
    if (advance) begin
      pixel_data <= pix_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/dxt1_palette.sv =====
// ----------------------------------------------------------------------------
// dxt1_palette
// Builds the four-entry RGBA palette from the two RGB565 endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt1_palette (
  input  wire logic [15:0]               endpoint_a,
  input  wire logic [15:0]               endpoint_b,
  output dxt1_pkg::color_t [3:0]         palette
);
  import dxt1_pkg::*;

  logic [7:0] ea [3];
  logic [7:0] eb [3];
  logic [7:0] mix2 [3];
  logic [7:0] mix3 [3];
  logic       four_color;

  // endpoint expansion to 8 bits per channel
  always_comb begin
    ea[0] = expand5(endpoint_a[15:11]);
    ea[1] = expand6(endpoint_a[10:5]);
    ea[2] = expand5(endpoint_a[4:0]);
    eb[0] = expand5(endpoint_b[15:11]);
    eb[1] = expand6(endpoint_b[10:5]);
    eb[2] = expand5(endpoint_b[4:0]);
  end

  assign four_color = endpoint_a > endpoint_b;

  // interpolated entries per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (four_color) begin
        mix2[ch] = div3((10'(ea[ch]) << 1) + 10'(eb[ch]));
        mix3[ch] = div3(10'(ea[ch]) + (10'(eb[ch]) << 1));
      end else begin
        mix2[ch] = 8'((9'(ea[ch]) + 9'(eb[ch])) >> 1);
        mix3[ch] = 8'd0;
      end
    end
  end

  // palette assembly
  always_comb begin
    palette[0] = '{red: ea[0], green: ea[1], blue: ea[2], alpha: AlphaOpaque};
    palette[1] = '{red: eb[0], green: eb[1], blue: eb[2], alpha: AlphaOpaque};
    palette[2] = '{red: mix2[0], green: mix2[1], blue: mix2[2], alpha: AlphaOpaque};
    palette[3] = '{red: mix3[0], green: mix3[1], blue: mix3[2],
                   alpha: four_color ? AlphaOpaque : AlphaClear};
  end

endmodule

`default_nettype wire
